// ----- src/ptbo_pkg.sv -----
// ptbo_pkg: types and constants for the periodic timer bank.
// No dependencies.
package ptbo_pkg;

  localparam int unsigned TW = 63;
  localparam int unsigned OW = 31;
  localparam logic [TW-1:0] MAX63 = {TW{1'b1}};
  localparam logic [OW-1:0] MAX31 = {OW{1'b1}};
  localparam logic [6:0] ALARM_SIGNAL = 7'd14;
  localparam logic [TW-1:0] CPU_PROBE = 63'd1000000;

  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_ARM    = 3'd1;
  localparam logic [2:0] FN_REM    = 3'd2;
  localparam logic [2:0] FN_OVR    = 3'd3;
  localparam logic [2:0] FN_DEL    = 3'd4;
  localparam logic [2:0] FN_POLL   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_OVFL  = 2'd3;

  localparam logic [1:0] CLK_CPU   = 2'd2;
  localparam logic [1:0] CLK_BAD   = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SIG  = 2'd1;
  localparam logic [1:0] MODE_ALRM = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_DIV, S_FIN, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]    func;
    logic [4:0]    timer_index;
    logic [TW-1:0] now;
    logic [1:0]    clock_sel;
    logic [1:0]    notify_mode;
    logic [6:0]    signal_number;
    logic          absolute;
    logic [TW-1:0] first_ticks;
    logic [TW-1:0] period_ticks;
    logic          pending_before;
    logic          pending_after;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [4:0]    slot_id;
    logic [TW-1:0] remaining_ticks;
    logic [TW-1:0] period_out;
    logic [OW-1:0] overrun_count;
    logic          raise_signal;
    logic [6:0]    raised_signal;
    logic [TW-1:0] wait_ticks;
  } rsp_t;

endpackage

// ----- src/periodic_timer_bank_overrun.sv -----
// periodic_timer_bank_overrun: top level of the timer bank.
// Depends on ptbo_pkg.
//
// One command is taken when start is high and busy low. Its result is shown for one cycle
// with done_o, and the receiver cannot stall it. Create scans the slots one per cycle.
// Other commands pass through the read, finish and output states. Read overrun and poll
// of an expired periodic timer are the exceptions: they run a radix-2 restoring divider
// for 63 quotient bits, one bit a cycle, in the divide state between two passes through finish.
// busy drops in the cycle that shows the result, so the next command can be taken at the
// same edge as that result. The slot state is held in registers with reset values.
module periodic_timer_bank_overrun import ptbo_pkg::*; #(
  parameter int unsigned NUM_TIMERS   = 32,
  parameter int unsigned SIGNAL_LIMIT = 65
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  // slot state
  logic          act_q  [NUM_TIMERS];
  logic [1:0]    clk_q  [NUM_TIMERS];
  logic          ntf_q  [NUM_TIMERS];
  logic [6:0]    sig_q  [NUM_TIMERS];
  logic [TW-1:0] dl_q   [NUM_TIMERS];
  logic [TW-1:0] per_q  [NUM_TIMERS];
  logic [OW-1:0] ovr_q  [NUM_TIMERS];
  logic          pend_q [NUM_TIMERS];

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   done_q;
  logic [CW-1:0] scan_q;
  logic [IW-1:0] s_q;
  // working copies of the addressed slot
  logic [TW-1:0] dl_w_q, per_w_q;
  logic [OW-1:0] ovr_w_q;
  logic          pend_w_q, ntf_w_q;
  logic [1:0]    clk_w_q;
  logic [6:0]    sig_w_q;
  logic          valid_q;
  // divider
  logic [TW-1:0] rem_q, quo_q, dvd_q;
  logic [6:0]    dcnt_q;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  logic accept;
  assign accept = start && !busy;

  // divider counter parks at all ones once the quotient is complete
  logic div_done;
  assign div_done = (dcnt_q == 7'd127);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        state_d = (req_i.func == FN_CREATE) ? S_SCAN : S_READ;
      end
      S_SCAN: if (scan_q >= CW'(NUM_TIMERS) || !act_q[scan_q[IW-1:0]]) state_d = S_OUT;
      S_READ: state_d = S_FIN;
      S_DIV:  if (dcnt_q == 7'd0) state_d = S_FIN;
      S_FIN: begin
        if (valid_q && (req_q.func == FN_OVR || req_q.func == FN_POLL) &&
            dl_w_q != '0 && req_q.now >= dl_w_q && per_w_q != '0 && !div_done)
          state_d = S_DIV;
        else
          state_d = S_OUT;
      end
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // expiry arithmetic on the working copies after division
  logic          exp_hit;
  logic [TW-1:0] base, dl_new, wait_v;
  logic [TW:0]   cnt_w, sum_w;
  logic [OW:0]   ovr_sum;
  logic          raise_v;
  logic [OW-1:0] ovr_new, cnt_sat;
  logic          pend_new;

  always_comb begin
    exp_hit  = (dl_w_q != '0) && (req_q.now >= dl_w_q);
    base     = req_q.now - rem_q;
    sum_w    = {1'b0, base} + {1'b0, per_w_q};
    cnt_w    = (per_w_q != '0) ? ({1'b0, quo_q} + 64'd1) : 64'd1;
    cnt_sat  = (cnt_w > {{(TW+1-OW){1'b0}}, MAX31}) ? MAX31 : cnt_w[OW-1:0];
    ovr_sum  = {1'b0, ovr_w_q} + {1'b0, cnt_sat};
    dl_new   = (per_w_q == '0) ? '0 : (sum_w[TW] ? MAX63 : sum_w[TW-1:0]);
    raise_v  = 1'b0;
    ovr_new  = ovr_w_q;
    pend_new = pend_w_q;
    if (ntf_w_q) begin
      priority if (req_q.pending_before) begin
        ovr_new  = ovr_sum[OW] ? MAX31 : ovr_sum[OW-1:0];
        pend_new = 1'b1;
      end else if (pend_w_q) begin
        ovr_new  = ovr_sum[OW] ? MAX31 : ovr_sum[OW-1:0];
        pend_new = 1'b0;
      end else begin
        ovr_new  = (cnt_w > {{(TW+1-OW){1'b0}}, MAX31}) ? MAX31 : cnt_w[OW-1:0] - 1'b1;
        pend_new = req_q.pending_after;
        raise_v  = 1'b1;
      end
    end
    wait_v = (dl_new > req_q.now) ? dl_new - req_q.now : '0;
    if (clk_w_q == CLK_CPU && wait_v > CPU_PROBE) wait_v = CPU_PROBE;
  end

  logic create_bad;
  assign create_bad = (req_q.clock_sel == CLK_BAD) || (req_q.notify_mode == MODE_BAD) ||
                      (req_q.notify_mode == MODE_SIG && (req_q.signal_number == 7'd0 ||
                       {1'b0, req_q.signal_number} >= 8'(SIGNAL_LIMIT)));

  // relative arm past the top of the tick range
  logic arm_ovf;
  assign arm_ovf = req_q.first_ticks != '0 && !req_q.absolute &&
                   req_q.first_ticks > MAX63 - req_q.now;

  // create result for the current scan position
  rsp_t scan_rsp;
  always_comb begin
    scan_rsp = '0;
    if (create_bad) scan_rsp.status = ST_INVAL;
    else if (scan_q >= CW'(NUM_TIMERS)) scan_rsp.status = ST_FULL;
    else scan_rsp.slot_id = 5'(scan_q);
  end

  // result of the finishing step, built from the slot copies
  rsp_t fin_rsp;
  always_comb begin
    fin_rsp = '0;
    fin_rsp.slot_id = req_q.timer_index;
    if (!valid_q) begin
      fin_rsp.status = ST_INVAL;
    end else begin
      fin_rsp.remaining_ticks = (dl_w_q != '0 && dl_w_q > req_q.now) ?
                                dl_w_q - req_q.now : '0;
      fin_rsp.period_out = per_w_q;
      unique case (req_q.func)
        FN_ARM: if (arm_ovf) fin_rsp.status = ST_OVFL;
        FN_OVR: begin
          fin_rsp.overrun_count = exp_hit ? ovr_new : ovr_w_q;
          fin_rsp.raise_signal  = exp_hit && raise_v;
          fin_rsp.raised_signal = (exp_hit && raise_v) ? sig_w_q : 7'd0;
        end
        FN_POLL: if (dl_w_q != '0) begin
          if (exp_hit) begin
            fin_rsp.overrun_count = raise_v ? ovr_new : '0;
            fin_rsp.raise_signal  = raise_v;
            fin_rsp.raised_signal = raise_v ? sig_w_q : 7'd0;
            fin_rsp.wait_ticks    = (dl_new != '0) ? wait_v : '0;
          end else begin
            fin_rsp.wait_ticks = (clk_w_q == CLK_CPU && dl_w_q - req_q.now > CPU_PROBE) ?
                                 CPU_PROBE : dl_w_q - req_q.now;
          end
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      dcnt_q  <= 7'd0;
      scan_q  <= '0;
      rsp_q   <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        act_q[i] <= 1'b0; clk_q[i] <= '0; ntf_q[i] <= 1'b0; sig_q[i] <= '0;
        dl_q[i] <= '0; per_q[i] <= '0; ovr_q[i] <= '0; pend_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          scan_q <= '0;
          dcnt_q <= 7'd0;
        end
        S_SCAN: begin
          if (create_bad) begin
            rsp_q  <= scan_rsp;
            scan_q <= CW'(NUM_TIMERS);
          end else if (scan_q >= CW'(NUM_TIMERS)) begin
            rsp_q <= scan_rsp;
          end else if (!act_q[scan_q[IW-1:0]]) begin
            act_q[scan_q[IW-1:0]]  <= 1'b1;
            clk_q[scan_q[IW-1:0]]  <= req_q.clock_sel;
            ntf_q[scan_q[IW-1:0]]  <= (req_q.notify_mode != MODE_NONE);
            sig_q[scan_q[IW-1:0]]  <= (req_q.notify_mode == MODE_SIG) ? req_q.signal_number :
                                      (req_q.notify_mode == MODE_ALRM) ? ALARM_SIGNAL : 7'd0;
            dl_q[scan_q[IW-1:0]]   <= '0;
            per_q[scan_q[IW-1:0]]  <= '0;
            ovr_q[scan_q[IW-1:0]]  <= '0;
            pend_q[scan_q[IW-1:0]] <= 1'b0;
            rsp_q <= scan_rsp;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_DIV: begin
          if (dcnt_q == 7'd0) dcnt_q <= 7'd127;
          else dcnt_q <= dcnt_q - 1'b1;
        end
        S_FIN: begin
          if (state_d == S_DIV) begin
            // one quotient bit per cycle over the full tick width
            dcnt_q <= 7'(TW - 1);
          end else begin
            rsp_q <= fin_rsp;
            if (valid_q) begin
              unique case (req_q.func)
                FN_ARM: begin
                  if (!arm_ovf) begin
                    per_q[s_q] <= req_q.period_ticks;
                    ovr_q[s_q] <= '0;
                    dl_q[s_q]  <= (req_q.first_ticks == '0) ? '0 :
                                  req_q.absolute ? req_q.first_ticks :
                                  req_q.now + req_q.first_ticks;
                  end
                end
                FN_OVR: begin
                  if (exp_hit) begin
                    dl_q[s_q]  <= dl_new;
                    ovr_q[s_q] <= ovr_new;
                  end
                  pend_q[s_q] <= 1'b0;
                end
                FN_DEL: begin
                  act_q[s_q] <= 1'b0; clk_q[s_q] <= '0; ntf_q[s_q] <= 1'b0;
                  sig_q[s_q] <= '0; dl_q[s_q] <= '0; per_q[s_q] <= '0;
                  ovr_q[s_q] <= '0; pend_q[s_q] <= 1'b0;
                end
                FN_POLL: begin
                  if (exp_hit) begin
                    dl_q[s_q]   <= dl_new;
                    ovr_q[s_q]  <= ovr_new;
                    pend_q[s_q] <= pend_new;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_OUT: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers: command capture, slot copy, divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      s_q   <= IW'(req_i.timer_index);
    end
    if (state_q == S_READ) begin
      dl_w_q   <= dl_q[s_q];
      per_w_q  <= per_q[s_q];
      ovr_w_q  <= ovr_q[s_q];
      pend_w_q <= pend_q[s_q];
      ntf_w_q  <= ntf_q[s_q];
      clk_w_q  <= clk_q[s_q];
      sig_w_q  <= sig_q[s_q];
    end
    if (state_q == S_FIN && state_d == S_DIV) begin
      dvd_q  <= req_q.now - dl_w_q;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (state_q == S_DIV) begin
      // one restoring step per cycle
      if ({rem_q, dvd_q[TW-1]} >= {1'b0, per_w_q}) begin
        rem_q <= TW'({rem_q, dvd_q[TW-1]} - {1'b0, per_w_q});
        quo_q <= {quo_q[TW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[TW-2:0], dvd_q[TW-1]};
        quo_q <= {quo_q[TW-2:0], 1'b0};
      end
      dvd_q <= {dvd_q[TW-2:0], 1'b0};
    end else if (state_q == S_READ) begin
      rem_q <= '0;
      quo_q <= '0;
    end
  end

  // slot validity, known after capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (state_q == S_READ)
      valid_q <= (req_q.func <= FN_POLL) &&
                 ({4'b0, req_q.timer_index} < 9'(NUM_TIMERS)) && act_q[s_q];
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held two cycles");
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("done outside idle");
  a_busy_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item not busy");

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for periodic_timer_bank_overrun.
// Depends on ptbo_pkg and the top level in src; a local timer-bank model predicts each result.
`timescale 1ns / 1ps

module tb;
  import ptbo_pkg::*;

  localparam int NT = 32;
  localparam int SIGLIM = 65;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  periodic_timer_bank_overrun u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // model of the bank
  logic          m_active [NT];
  logic [1:0]    m_clock  [NT];
  logic          m_notify [NT];
  logic [6:0]    m_signal [NT];
  logic [TW-1:0] m_due    [NT];
  logic [TW-1:0] m_period [NT];
  logic [OW-1:0] m_ovr    [NT];
  logic          m_pend   [NT];

  rsp_t pending_rsp[$];
  int   err_cnt = 0;
  int   rsp_cnt = 0;
  int   send_idle = 0;  // percent
  int   n_raise = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    err_cnt++;
    $display("tb: mismatch %s got %0h exp %0h (transfer %0d)", what, got, exp, rsp_cnt);
  endtask

  function automatic logic [OW-1:0] sat_add31(logic [OW-1:0] tot, logic [63:0] more);
    logic [63:0] t;
    t = {33'd0, tot};
    return (more > ({33'd0, MAX31} - t)) ? MAX31 : OW'(t + more);
  endfunction

  // expiry on one slot; returns 1 when a signal is raised
  function automatic bit expire(int s, logic [TW-1:0] now, bit pb, bit pa);
    logic [63:0] cnt, el, base, due, per;
    cnt = 1;
    due = {1'b0, m_due[s]};
    per = {1'b0, m_period[s]};
    if (due == 0 || now < due) return 0;
    if (per != 0) begin
      el = now - due;
      base = now - (el % per);
      cnt += el / per;
      m_due[s] = (per > {1'b0, MAX63} - base) ? MAX63 : TW'(base + per);
    end else begin
      m_due[s] = '0;
    end
    if (!m_notify[s]) return 0;
    if (pb) begin
      m_ovr[s] = sat_add31(m_ovr[s], cnt);
      m_pend[s] = 1;
      return 0;
    end
    if (m_pend[s]) begin
      m_ovr[s] = sat_add31(m_ovr[s], cnt);
      m_pend[s] = 0;
      return 0;
    end
    m_ovr[s] = (cnt > {33'd0, MAX31}) ? MAX31 : OW'(cnt - 1);
    m_pend[s] = pa;
    return 1;
  endfunction

  function automatic void clear_slot(int s);
    m_active[s] = 0; m_clock[s] = 0; m_notify[s] = 0; m_signal[s] = 0;
    m_due[s] = 0; m_period[s] = 0; m_ovr[s] = 0; m_pend[s] = 0;
  endfunction

  function automatic rsp_t predict_timer(req_t r);
    rsp_t o;
    int s, found;
    bit rs;
    o = '0;
    o.slot_id = r.timer_index;
    s = r.timer_index;
    rs = 0;
    if (r.func == FN_CREATE) begin
      o.slot_id = 0;
      if (r.clock_sel == CLK_BAD || r.notify_mode == MODE_BAD ||
          (r.notify_mode == MODE_SIG && (r.signal_number == 0 || r.signal_number >= SIGLIM)))
        o.status = ST_INVAL;
      else begin
        found = -1;
        for (int i = 0; i < NT; i++)
          if (!m_active[i] && found < 0) found = i;
        if (found < 0) o.status = ST_FULL;
        else begin
          clear_slot(found);
          m_active[found] = 1;
          m_clock[found] = r.clock_sel;
          m_notify[found] = (r.notify_mode != MODE_NONE);
          m_signal[found] = (r.notify_mode == MODE_SIG) ? r.signal_number :
                            (r.notify_mode == MODE_ALRM) ? ALARM_SIGNAL : 7'd0;
          o.slot_id = 5'(found);
        end
      end
    end else if (r.func > FN_POLL || !m_active[s]) begin
      o.status = ST_INVAL;
    end else begin
      o.remaining_ticks = (m_due[s] != 0 && m_due[s] > r.now) ? m_due[s] - r.now : '0;
      o.period_out = m_period[s];
      case (r.func)
        FN_ARM: begin
          if (r.first_ticks != 0 && !r.absolute && r.first_ticks > MAX63 - r.now)
            o.status = ST_OVFL;
          else begin
            m_period[s] = r.period_ticks;
            m_ovr[s] = 0;
            if (r.first_ticks == 0) m_due[s] = 0;
            else if (r.absolute) m_due[s] = r.first_ticks;
            else m_due[s] = r.now + r.first_ticks;
          end
        end
        FN_OVR: begin
          rs = expire(s, r.now, r.pending_before, r.pending_after);
          o.overrun_count = m_ovr[s];
          m_pend[s] = 0;
        end
        FN_DEL: clear_slot(s);
        FN_POLL: begin
          if (m_due[s] != 0) begin
            rs = expire(s, r.now, r.pending_before, r.pending_after);
            if (rs) o.overrun_count = m_ovr[s];
            if (m_due[s] != 0) begin
              o.wait_ticks = (m_due[s] > r.now) ? m_due[s] - r.now : '0;
              if (m_clock[s] == CLK_CPU && o.wait_ticks > CPU_PROBE)
                o.wait_ticks = CPU_PROBE;
            end
          end
        end
        default: ;
      endcase
      o.raise_signal = rs;
      if (rs) o.raised_signal = m_signal[s];
    end
    return o;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rsp_t e;
      rsp_cnt++;
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        $display("tb: result with nothing expected");
      end else begin
        e = pending_rsp.pop_front();
        if (e.raise_signal) n_raise++;
        if (rsp_o.status !== e.status) report("status", rsp_o.status, e.status);
        if (rsp_o.slot_id !== e.slot_id) report("slot_id", rsp_o.slot_id, e.slot_id);
        if (rsp_o.remaining_ticks !== e.remaining_ticks)
          report("remaining", rsp_o.remaining_ticks, e.remaining_ticks);
        if (rsp_o.period_out !== e.period_out) report("period", rsp_o.period_out, e.period_out);
        if (rsp_o.overrun_count !== e.overrun_count)
          report("overrun", rsp_o.overrun_count, e.overrun_count);
        if (rsp_o.raise_signal !== e.raise_signal)
          report("raise", rsp_o.raise_signal, e.raise_signal);
        if (rsp_o.raised_signal !== e.raised_signal)
          report("signal", rsp_o.raised_signal, e.raised_signal);
        if (rsp_o.wait_ticks !== e.wait_ticks) report("wait", rsp_o.wait_ticks, e.wait_ticks);
      end
    end
  end

  // one command transfer; start stays high until the next call or a hold-off
  task automatic send_cmd(input req_t r);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.push_back(predict_timer(r));
  endtask

  // drop start and wait until every expected result has come
  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [TW-1:0] rand63();
    return TW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [TW-1:0] rand_ticks();
    case ($urandom_range(5))
      0: return rand63();
      1: return MAX63 - $urandom_range(50);
      2: return $urandom_range(3);
      default: return $urandom_range(5000);
    endcase
  endfunction

  function automatic req_t rand_req(bit noise);
    req_t r;
    r = '0;
    r.now = rand_ticks();
    r.first_ticks = rand_ticks();
    r.period_ticks = ($urandom_range(3) == 0) ? 63'd0 : rand_ticks();
    r.absolute = 1'($urandom_range(1));
    r.pending_before = ($urandom_range(3) == 0);
    r.pending_after = 1'($urandom_range(1));
    r.signal_number = noise ? 7'($urandom()) : 7'($urandom_range(1, SIGLIM - 1));
    r.clock_sel = noise ? 2'($urandom()) : 2'($urandom_range(2));
    r.notify_mode = noise ? 2'($urandom()) : 2'($urandom_range(2));
    r.timer_index = noise ? 5'($urandom()) : 5'($urandom_range(5));
    r.func = noise ? 3'($urandom()) : 3'($urandom_range(5));
    return r;
  endfunction

  task automatic drain();
    hold_off();
    repeat (80) @(posedge clk_i);
  endtask

  task automatic test_directed();
    req_t r;
    r = '0; r.func = FN_REM; r.timer_index = 5'd31; send_cmd(r);   // inactive slot
    r = '0; r.func = 3'd6; send_cmd(r);
    r.func = 3'd7; send_cmd(r);
    r = '0; r.func = FN_CREATE; r.clock_sel = CLK_BAD; send_cmd(r);
    r.clock_sel = 0; r.notify_mode = MODE_BAD; send_cmd(r);
    r.notify_mode = MODE_SIG; r.signal_number = 0; send_cmd(r);
    r.signal_number = SIGLIM; send_cmd(r);
    r.signal_number = 7'd127; send_cmd(r);
    r.signal_number = SIGLIM - 1; send_cmd(r);                     // slot 0, signal
    r.notify_mode = MODE_ALRM; r.clock_sel = CLK_CPU; send_cmd(r); // slot 1, alarm cpu
    r = '0; r.func = FN_ARM; r.now = MAX63; r.first_ticks = 1; send_cmd(r);  // overflow
    r.now = 10; r.first_ticks = 100; r.period_ticks = 7; send_cmd(r);
    r.func = FN_REM; r.now = 20; send_cmd(r);
    r.func = FN_POLL; r.now = 1000; r.pending_after = 1; send_cmd(r);
    r.func = FN_POLL; r.now = 2000; r.pending_after = 0; send_cmd(r);
    r.func = FN_OVR; r.now = MAX63; r.pending_before = 1; send_cmd(r);
    r = '0; r.func = FN_ARM; r.timer_index = 1; r.absolute = 1;
    r.first_ticks = 5; r.period_ticks = MAX63; send_cmd(r);
    r.func = FN_POLL; r.now = MAX63 - 1; send_cmd(r);                // saturates deadline
    r = '0; r.func = FN_ARM; r.timer_index = 1; r.first_ticks = 3; send_cmd(r);
    r.func = FN_POLL; r.now = 0; send_cmd(r);                        // cpu wait, one-shot
    r.func = FN_POLL; r.now = 9; send_cmd(r);
    r.func = FN_DEL; send_cmd(r);
    r.func = FN_POLL; send_cmd(r);
    drain();
  endtask

  task automatic test_full_bank();
    req_t r;
    r = '0;
    for (int i = 0; i < NT + 1; i++) send_cmd(r);
    r.func = FN_DEL;
    for (int i = 2; i < NT; i++) begin
      r.timer_index = 5'(i);
      send_cmd(r);
    end
    drain();
  endtask

  task automatic test_random(input int n, input int idle);
    send_idle = idle;
    for (int i = 0; i < n; i++) begin
      // hold off once mid-phase until the bank has answered everything
      if (i == n / 2) hold_off();
      send_cmd(rand_req($urandom_range(9) == 0));
    end
    send_idle = 0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < NT; i++) clear_slot(i);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_bank();
    test_random(115, 0);
    test_random(115, 74);
    test_random(115, 0);
    test_random(115, 11);
    $display("tb: %0d results checked, %0d raised signals", rsp_cnt, n_raise);
    $display("tb: covered create errors, full bank, arm overflow, expiry and overruns");
    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/ptbo_pkg.sv
src/periodic_timer_bank_overrun.sv
sim/tb.sv
